/* rtl/core/rds_text_group_assembler_defines.svh */
// Assertion macros, clocked on clk_i; RTGA_ASSERT is gated by rst_ni.
`ifndef RDS_TEXT_GROUP_ASSEMBLER_DEFINES_SVH
`define RDS_TEXT_GROUP_ASSEMBLER_DEFINES_SVH

// Check a property only while out of reset.
`define RTGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define RTGA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/rtga_pkg.sv */
package rtga_pkg;

  localparam int unsigned CmdQueueDepth = 2;
  localparam int unsigned ResQueueDepth = 2;

  localparam logic [4:0] KindGroup0A = 5'h00;
  localparam logic [4:0] KindGroup2A = 5'h04;
  localparam logic [7:0] CarriageRet = 8'h0D;
  localparam logic [6:0] NameChars   = 7'd8;
  localparam logic [6:0] AllChars    = 7'd72;
  localparam logic [3:0]  NameFull   = 4'hF;
  localparam logic [15:0] TextFull   = 16'hFFFF;

  typedef struct packed {
    logic        action;
    logic [15:0] block_a;
    logic [15:0] block_b;
    logic [15:0] block_c;
    logic [15:0] block_d;
    logic [6:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        complete;
    logic [15:0] program_id;
    logic [3:0]  name_mask;
    logic [15:0] text_mask;
    logic [7:0]  read_char;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_PI_ONLY,
    CMD_NAME,
    CMD_TEXT,
    CMD_READ_NAME,
    CMD_READ_TEXT,
    CMD_READ_NONE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [15:0] pi;
    logic [3:0]  seg;
    logic [31:0] data;
    logic        cr_hit;
    logic [3:0]  rd_row;
    logic [2:0]  rd_byte;
  } cmd_t;

endpackage

/* rtl/core/rtga_fifo.sv */
module rtga_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    if (ptr == PtrW'(Depth - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrW'(1);
    end
    return res;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/rtga_front.sv */
module rtga_front (
  input  logic              push_i,
  input  rtga_pkg::in_item_t in_item_i,
  input  logic              cmd_full_i,
  output logic              cmd_push_o,
  output rtga_pkg::cmd_t    cmd_o
);
  import rtga_pkg::*;

  logic [4:0]  kind;
  logic [7:0]  raw [4];
  logic [31:0] text_word;
  logic        cr_hit;
  logic [6:0]  text_idx;

  assign kind     = in_item_i.block_b[15:11];
  assign raw[0]   = in_item_i.block_c[15:8];
  assign raw[1]   = in_item_i.block_c[7:0];
  assign raw[2]   = in_item_i.block_d[15:8];
  assign raw[3]   = in_item_i.block_d[7:0];
  assign text_idx = in_item_i.read_index - NameChars;

  // Replace carriage returns by zero.
  always_comb begin
    cr_hit    = 1'b0;
    text_word = '0;
    for (int k = 0; k < 4; k++) begin
      if (raw[k] == CarriageRet) begin
        cr_hit = 1'b1;
      end else begin
        text_word[(3 - k) * 8 +: 8] = raw[k];
      end
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.pi      = in_item_i.block_a;
    cmd_o.op      = CMD_PI_ONLY;
    if (in_item_i.action) begin
      if (in_item_i.read_index < NameChars) begin
        cmd_o.op      = CMD_READ_NAME;
        cmd_o.rd_byte = in_item_i.read_index[2:0];
      end else if (in_item_i.read_index < AllChars) begin
        cmd_o.op      = CMD_READ_TEXT;
        cmd_o.rd_row  = text_idx[5:2];
        cmd_o.rd_byte = {1'b0, text_idx[1:0]};
      end else begin
        cmd_o.op = CMD_READ_NONE;
      end
    end else if (kind == KindGroup0A) begin
      cmd_o.op   = CMD_NAME;
      cmd_o.seg  = {2'b00, in_item_i.block_b[1:0]};
      cmd_o.data = {16'h0000, in_item_i.block_d};
    end else if (kind == KindGroup2A && !in_item_i.block_b[4]) begin
      cmd_o.op     = CMD_TEXT;
      cmd_o.seg    = in_item_i.block_b[3:0];
      cmd_o.data   = text_word;
      cmd_o.cr_hit = cr_hit;
    end
  end

  assign cmd_push_o = push_i && !cmd_full_i;

endmodule

/* rtl/core/rtga_back.sv */
module rtga_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  rtga_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output rtga_pkg::out_item_t res_o
);
  import rtga_pkg::*;

  logic [15:0] pi_q, pi_d;
  logic [15:0] name_q [4];
  logic [15:0] name_d [4];
  logic [31:0] text_q [16];
  logic [31:0] text_d [16];
  logic [3:0]  name_seen_q, name_seen_d;
  logic [15:0] text_seen_q, text_seen_d;
  logic [7:0]  rd_char;
  logic [15:0] name_row;
  logic [31:0] text_row;
  logic        fire;

  assign fire     = cmd_valid_i && !res_full_i;
  assign name_row = name_q[cmd_i.rd_byte[2:1]];
  assign text_row = text_q[cmd_i.rd_row];

  always_comb begin
    pi_d        = pi_q;
    name_d      = name_q;
    text_d      = text_q;
    name_seen_d = name_seen_q;
    text_seen_d = text_seen_q;
    rd_char     = '0;
    if (fire) begin
      case (cmd_i.op)
        CMD_PI_ONLY: begin
          pi_d = cmd_i.pi;
        end
        CMD_NAME: begin
          pi_d                    = cmd_i.pi;
          name_d[cmd_i.seg[1:0]]  = cmd_i.data[15:0];
          name_seen_d             = name_seen_q | (4'b0001 << cmd_i.seg[1:0]);
        end
        CMD_TEXT: begin
          pi_d              = cmd_i.pi;
          text_d[cmd_i.seg] = cmd_i.data;
          text_seen_d       = (cmd_i.cr_hit ? TextFull : text_seen_q)
                              | (16'h0001 << cmd_i.seg);
        end
        CMD_READ_NAME: begin
          rd_char = cmd_i.rd_byte[0] ? name_row[7:0] : name_row[15:8];
        end
        CMD_READ_TEXT: begin
          case (cmd_i.rd_byte[1:0])
            2'd0:    rd_char = text_row[31:24];
            2'd1:    rd_char = text_row[23:16];
            2'd2:    rd_char = text_row[15:8];
            default: rd_char = text_row[7:0];
          endcase
        end
        default: begin
          rd_char = '0;
        end
      endcase
    end
  end

  always_comb begin
    res_o.complete   = (name_seen_d == NameFull) && (text_seen_d == TextFull);
    res_o.program_id = pi_d;
    res_o.name_mask  = name_seen_d;
    res_o.text_mask  = text_seen_d;
    res_o.read_char  = rd_char;
  end

  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pi_q        <= '0;
      name_seen_q <= '0;
      text_seen_q <= '0;
      for (int i = 0; i < 4; i++) begin
        name_q[i] <= '0;
      end
      for (int i = 0; i < 16; i++) begin
        text_q[i] <= '0;
      end
    end else begin
      pi_q        <= pi_d;
      name_seen_q <= name_seen_d;
      text_seen_q <= text_seen_d;
      name_q      <= name_d;
      text_q      <= text_d;
    end
  end

endmodule

/* rtl/core/rds_text_group_assembler.sv */
// RDS station name and radiotext assembler. Push one request per cycle
// while full is low (an RDS group or a character read); each request
// yields exactly one result, in order. Sustained rate is one request per
// clock while neither queue is full, set by the execute stage that
// updates the name, text and mask registers; a command queue in front and a
// result queue behind let either side stall independently. Reads see every
// group accepted before them. Reset clears the identifier, both character
// stores and both masks at once; no clearing pass is needed.
`include "rds_text_group_assembler_defines.svh"

module rds_text_group_assembler #(
  parameter int unsigned CmdDepth = rtga_pkg::CmdQueueDepth,
  parameter int unsigned ResDepth = rtga_pkg::ResQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  rtga_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output rtga_pkg::out_item_t out_item_o
);
  import rtga_pkg::*;

  cmd_t      front_cmd, back_cmd;
  logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic      res_push, res_full;
  out_item_t back_res;
  logic [$bits(cmd_t)-1:0]      cmd_vec;
  logic [$bits(out_item_t)-1:0] res_vec;

  rtga_front u_front (
    .push_i     (push),
    .in_item_i  (in_item_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd)
  );

  rtga_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_vec),
    .empty_o (cmd_empty)
  );

  assign back_cmd = cmd_t'(cmd_vec);
  assign full     = cmd_full;

  rtga_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  rtga_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_vec),
    .empty_o (empty)
  );

  assign out_item_o = out_item_t'(res_vec);

  `RTGA_ASSERT(a_res_no_overflow, res_push |-> !res_full, "result queue overflow")
  `RTGA_ASSERT(a_cmd_no_underflow, cmd_pop |-> !cmd_empty, "command queue underflow")
  `RTGA_ASSERT(a_masks_grow, (pop && !empty) |=> (empty || ((out_item_o.text_mask & $past(out_item_o.text_mask)) == $past(out_item_o.text_mask) && (out_item_o.name_mask & $past(out_item_o.name_mask)) == $past(out_item_o.name_mask))), "segment masks shrank between results")
  `RTGA_ASSERT(a_complete_match, !empty |-> (out_item_o.complete == ((out_item_o.name_mask == NameFull) && (out_item_o.text_mask == TextFull))), "completion flag disagrees with masks")

endmodule
